FILE: design/ccsf_pkg.sv
// Shared types and constants for the chunk center-of-mass spring force block.
// No dependencies.
`timescale 1ns / 1ps

package ccsf_pkg;

	localparam logic OP_CHUNK = 1'b0;
	localparam logic OP_ATOM  = 1'b1;

	localparam logic [31:0] SPRING_K_RESET = 32'd65536;

	localparam int unsigned CIDX_W = 9;

	// One accepted request as it travels from the front to the back.
	typedef struct packed {
		logic              opcode;
		logic [CIDX_W-1:0] chunk_index;
		logic              in_range;
		logic              first_of_step;
		logic [31:0]       com_x;
		logic [31:0]       com_y;
		logic [31:0]       com_z;
		logic [31:0]       mass_value;
		logic [31:0]       atom_force_x;
		logic [31:0]       atom_force_y;
		logic [31:0]       atom_force_z;
	} req_t;

	function automatic logic [31:0] sat32(input logic signed [64:0] v);
		logic [31:0] r;
		if (v > 65'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -65'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: design/ccsf_front.sv
// Front end: accepts requests, classifies chunk range, and queues them.
// Depends on ccsf_pkg.
`timescale 1ns / 1ps

module ccsf_front #(
	parameter int NUM_CHUNKS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ccsf_pkg::req_t      in_req,
	output logic                q_valid,
	input  logic                q_ready,
	output ccsf_pkg::req_t      q_req
);

	localparam int DEPTH = 2;

	ccsf_pkg::req_t fifo_q [DEPTH];
	logic           wptr_q, rptr_q;
	logic [1:0]     cnt_q;
	ccsf_pkg::req_t cls;

	always_comb begin
		cls = in_req;
		cls.in_range = (in_req.chunk_index != '0) &&
			(32'(in_req.chunk_index) <= 32'(NUM_CHUNKS));
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			fifo_q[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (in_valid && in_ready) wptr_q <= ~wptr_q;
			if (q_valid && q_ready) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !in_ready) else $error("ready while full");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !q_valid) else $error("valid while empty");

endmodule

FILE: design/ccsf_div.sv
// Radix-2 restoring divider, unsigned 64 / 32, one quotient bit per cycle.
// No package dependency.
`timescale 1ns / 1ps

module ccsf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [32:0] sh;
	logic        ge;

	assign sh = {rem_q[31:0], quo_q[63]};
	assign ge = sh >= {1'b0, dvs_q};
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (sh - {1'b0, dvs_q}) : sh;
			quo_q <= {quo_q[62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: design/ccsf_back.sv
// Back end: sequencer that executes chunk and atom requests on shared units.
// Depends on ccsf_pkg and ccsf_div.
`timescale 1ns / 1ps

module ccsf_back #(
	parameter int NUM_CHUNKS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        spring_k,
	input  logic               q_valid,
	output logic               q_ready,
	input  ccsf_pkg::req_t     q_req,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        new_force_x,
	output logic [31:0]        new_force_y,
	output logic [31:0]        new_force_z,
	output logic [63:0]        energy_sum,
	output logic               reference_captured
);

	localparam int ENT   = NUM_CHUNKS * 3;
	localparam int AW    = $clog2(ENT);
	localparam int CW    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_RD    = 11'b00000000010,
		S_DISP  = 11'b00000000100,
		S_SQ    = 11'b00000001000,
		S_DIV   = 11'b00000010000,
		S_DWAIT = 11'b00000100000,
		S_EN    = 11'b00001000000,
		S_ATOM  = 11'b00010000000,
		S_OUT   = 11'b00100000000,
		S_EMUL  = 11'b01000000000,
		S_EACC  = 11'b10000000000
	} st_t;

	st_t st_q;
	ccsf_pkg::req_t r_q;
	logic [1:0]  ax_q;
	logic [CW-1:0] cidx;
	logic [AW-1:0] addr;

	logic [31:0] refc_mem [ENT];
	logic [31:0] fpm_mem  [ENT];
	logic [NUM_CHUNKS-1:0] rvalid_q;
	logic [NUM_CHUNKS-1:0] fvalid_q;
	logic [31:0] ref_rd_q, fpm_rd_q;
	logic        cap_q;
	logic [32:0] d_q;
	logic [63:0] sq_q;
	logic [65:0] r2_q;
	logic [63:0] acc_q;
	logic [31:0] nf_q [3];
	logic        ref_we, fpm_we;
	logic [31:0] fpm_wd;
	logic [1:0]  em_q;
	logic [97:0] kr2_q;

	logic [31:0] com_a, frc_a;
	logic        div_start, div_done;
	logic [63:0] div_quo, prod_q;
	logic [31:0] dmag;

	assign cidx = CW'(r_q.chunk_index - 9'd1);
	assign addr = AW'(32'(cidx) * 3 + 32'(ax_q));

	always_comb begin
		case (ax_q)
			2'd0: begin com_a = r_q.com_x; frc_a = r_q.atom_force_x; end
			2'd1: begin com_a = r_q.com_y; frc_a = r_q.atom_force_y; end
			default: begin com_a = r_q.com_z; frc_a = r_q.atom_force_z; end
		endcase
	end

	assign dmag = d_q[32] ? 32'(-d_q) : d_q[31:0];

	ccsf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(prod_q), .divisor(r_q.mass_value),
		.done(div_done), .quotient(div_quo)
	);

	// Saturated signed force per mass from the quotient magnitude.
	always_comb begin
		if (d_q[32]) begin
			fpm_wd = (div_quo > 64'h8000_0000) ? 32'h8000_0000 : 32'(-div_quo[31:0]);
		end else begin
			fpm_wd = (div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
		end
	end

	assign ref_we = (st_q == S_RD) && r_q.opcode == ccsf_pkg::OP_CHUNK && r_q.in_range &&
		!rvalid_q[cidx];
	assign fpm_we = (st_q == S_DWAIT && div_done) ||
		(st_q == S_SQ && r_q.mass_value == '0);

	always_ff @(posedge clk) begin
		if (ref_we) refc_mem[addr] <= com_a;
		ref_rd_q <= refc_mem[addr];
		if (fpm_we) fpm_mem[addr] <= (r_q.mass_value == '0) ? 32'd0 : fpm_wd;
		fpm_rd_q <= fpm_mem[addr];
	end

	assign div_start = (st_q == S_DIV);
	assign q_ready   = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign new_force_x = nf_q[0];
	assign new_force_y = nf_q[1];
	assign new_force_z = nf_q[2];
	assign energy_sum  = acc_q;
	assign reference_captured = cap_q;

	logic signed [64:0] corr, nf_full;
	logic [63:0] pm;
	logic [63:0] e_val, e_sum;
	logic [31:0] r2_part;
	logic [63:0] pp;
	logic [97:0] kr2_pp;
	always_comb begin
		pm   = prod_q;
		corr = prod_q[63] ? -65'(signed'({1'b0, 64'(-pm) >> 16}))
			: 65'(signed'({1'b0, pm >> 16}));
		nf_full = 65'(signed'(frc_a)) - corr;
		// k * r2 one 32-bit slice of r2 per cycle
		case (em_q)
			2'd0: r2_part = r2_q[31:0];
			2'd1: r2_part = r2_q[63:32];
			default: r2_part = {30'b0, r2_q[65:64]};
		endcase
		pp = 64'(spring_k) * 64'(r2_part);
		case (em_q)
			2'd0: kr2_pp = {34'b0, pp};
			2'd1: kr2_pp = {2'b0, pp, 32'b0};
			default: kr2_pp = {pp[33:0], 64'b0};
		endcase
		e_val = (kr2_q[97:81] != '0) ? '1 : kr2_q[80:17];
		e_sum = acc_q + e_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			rvalid_q <= '0;
			fvalid_q <= '0;
			acc_q    <= '0;
			ax_q     <= '0;
			cap_q    <= 1'b0;
			em_q     <= '0;
		end else begin
			case (st_q)
				S_IDLE: if (q_valid) begin
					r_q   <= q_req;
					ax_q  <= '0;
					cap_q <= 1'b0;
					r2_q  <= '0;
					for (int i = 0; i < 3; i++) nf_q[i] <= '0;
					if (q_req.first_of_step) acc_q <= '0;
					st_q  <= S_RD;
				end
				S_RD: begin
					if (ref_we) cap_q <= 1'b1;
					if (r_q.opcode == ccsf_pkg::OP_ATOM) st_q <= S_ATOM;
					else if (!r_q.in_range) st_q <= S_OUT;
					else st_q <= S_DISP;
				end
				S_DISP: begin
					d_q  <= (cap_q || !rvalid_q[cidx]) ? 33'd0 :
						33'(signed'(com_a)) - 33'(signed'(ref_rd_q));
					st_q <= S_SQ;
				end
				S_SQ: begin
					sq_q   <= 64'(dmag) * 64'(dmag);
					prod_q <= 64'(spring_k) * 64'(dmag);
					st_q   <= (r_q.mass_value == '0) ? S_EN : S_DIV;
				end
				S_DIV: begin
					r2_q <= r2_q + 66'(sq_q);
					st_q <= S_DWAIT;
				end
				S_DWAIT: if (div_done) st_q <= S_EN;
				S_EN: begin
					if (ax_q == 2'd2) begin
						rvalid_q[cidx] <= 1'b1;
						fvalid_q[cidx] <= 1'b1;
						em_q  <= '0;
						kr2_q <= '0;
						st_q  <= (r_q.mass_value != '0) ? S_EMUL : S_OUT;
					end else begin
						ax_q <= ax_q + 2'd1;
						st_q <= S_RD;
					end
				end
				S_EMUL: begin
					kr2_q <= kr2_q + kr2_pp;
					em_q  <= em_q + 2'd1;
					if (em_q == 2'd2) st_q <= S_EACC;
				end
				S_EACC: begin
					acc_q <= (e_sum < e_val) ? '1 : e_sum;
					st_q  <= S_OUT;
				end
				S_ATOM: begin
					// two passes per axis: multiply, then correct
					if (!cap_q) begin
						prod_q <= (r_q.in_range && fvalid_q[cidx]) ?
							64'(65'(signed'(fpm_rd_q)) * 65'(signed'({1'b0, r_q.mass_value})))
							: 64'd0;
						cap_q <= 1'b1;
					end else begin
						nf_q[ax_q] <= ccsf_pkg::sat32(nf_full);
						cap_q <= 1'b0;
						if (ax_q == 2'd2) st_q <= S_OUT;
						else begin
							ax_q <= ax_q + 2'd1;
							st_q <= S_RD;
						end
					end
				end
				S_OUT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_cap_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && r_q.opcode == ccsf_pkg::OP_ATOM |-> !reference_captured)
		else $error("capture flagged on atom request");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !q_ready) else $error("took request while result pending");
	a_div_once: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> st_q == S_DWAIT) else $error("divider start out of sequence");

endmodule

FILE: design/chunk_com_spring_force.sv
// Chunk center-of-mass harmonic restraint, top level.
// A chunk request makes three axis passes, each waiting on the 64-step serial divider,
// then accumulates energy. A zero-mass chunk skips the divider and the energy step;
// a no-chunk record goes straight to the result. The back end holds one request
// at a time and takes the next only after its result is accepted.
// Reset: asynchronous active low; clears spring_k to 1.0, energy, valid bits.
`timescale 1ns / 1ps

module chunk_com_spring_force #(
	parameter int NUM_CHUNKS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [8:0]  chunk_index,
	input  logic        first_of_step,
	input  logic [31:0] com_x,
	input  logic [31:0] com_y,
	input  logic [31:0] com_z,
	input  logic [31:0] mass_value,
	input  logic [31:0] atom_force_x,
	input  logic [31:0] atom_force_y,
	input  logic [31:0] atom_force_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] new_force_x,
	output logic [31:0] new_force_y,
	output logic [31:0] new_force_z,
	output logic [63:0] energy_sum,
	output logic        reference_captured
);

	logic [31:0] spring_k_q;
	ccsf_pkg::req_t in_req, q_req;
	logic q_valid, q_ready;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? spring_k_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) spring_k_q <= ccsf_pkg::SPRING_K_RESET;
		else if (psel && penable && pwrite && paddr == 2'd0) spring_k_q <= pwdata;
	end

	always_comb begin
		in_req = '0;
		in_req.opcode = opcode;
		in_req.chunk_index = chunk_index;
		in_req.first_of_step = first_of_step;
		in_req.com_x = com_x;
		in_req.com_y = com_y;
		in_req.com_z = com_z;
		in_req.mass_value = mass_value;
		in_req.atom_force_x = atom_force_x;
		in_req.atom_force_y = atom_force_y;
		in_req.atom_force_z = atom_force_z;
	end

	ccsf_front #(.NUM_CHUNKS(NUM_CHUNKS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	ccsf_back #(.NUM_CHUNKS(NUM_CHUNKS)) u_back (
		.clk(clk), .arst_n(arst_n), .spring_k(spring_k_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_force_x(new_force_x), .new_force_y(new_force_y), .new_force_z(new_force_z),
		.energy_sum(energy_sum), .reference_captured(reference_captured)
	);

endmodule
